[src/nps_pkg.sv]
// Shared types and constants for the non-preemptive priority scheduler.
package nps_pkg;

    // Field widths of one input item and one result item.
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 23;
    localparam int TOT_W  = 29;
    localparam int PID_W  = 7;

    // Controller states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_OUT,
        S_OUT_WAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store the accepted item
        logic run_init;   // clear the run totals
        logic scan_init;  // clear the best-candidate and earliest-pending trackers
        logic scan_rd;    // read a process entry for selection
        logic commit;     // run the selected process to completion
        logic jump;       // advance the clock to the earliest pending arrival
        logic out_rd;     // read an entry for result output
        logic out_last;   // this output read is the final one of the run
        logic finish;     // return counters and done flags to their reset values
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic found;      // an arrived, unfinished process was seen in the last scan
        logic pending;    // an unfinished process was seen in the last scan
    } t_status;

endpackage

[src/nps_ctrl.sv]
// Controller state machine for the non-preemptive priority scheduler.
module nps_ctrl #(
    parameter int MAX_PROCS = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 i_last_process,
    input  logic [CNT_W-1:0]     i_count,
    input  nps_pkg::t_status     i_status,
    output nps_pkg::t_cmd        o_cmd,
    output logic [IDX_W-1:0]     o_addr,
    output logic                 busy
);
    import nps_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             accept;
    logic             idx_last;
    logic [CNT_W-1:0] cnt_last;

    assign accept   = start && (r_state == S_LOAD);
    assign cnt_last = i_count - CNT_W'(1);
    assign idx_last = (CNT_W'(r_idx) == cnt_last);
    assign busy     = (r_state != S_LOAD);
    assign o_addr   = r_idx;

    // State and index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and next index.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_LOAD: begin
                if (accept && i_last_process) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (idx_last) begin
                    n_state = S_SCAN_WAIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SCAN_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_idx = '0;
                if (i_status.found || i_status.pending) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (idx_last) begin
                    n_state = S_OUT_WAIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_OUT_WAIT: begin
                n_state = S_LOAD;
                n_idx   = '0;
            end
            default: begin
                n_state = S_LOAD;
                n_idx   = '0;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = accept;
                if (accept && i_last_process) begin
                    o_cmd.run_init  = 1'b1;
                    o_cmd.scan_init = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            S_SCAN_WAIT: begin
                o_cmd = '0;
            end
            S_DECIDE: begin
                o_cmd.scan_init = 1'b1;
                o_cmd.commit    = i_status.found;
                o_cmd.jump      = !i_status.found && i_status.pending;
            end
            S_OUT: begin
                o_cmd.out_rd   = 1'b1;
                o_cmd.out_last = idx_last;
            end
            S_OUT_WAIT: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[src/nps_dpath.sv]
// Datapath of the scheduler: process stores, selection scan, clock and results.
module nps_dpath #(
    parameter int MAX_PROCS = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nps_pkg::t_cmd               i_cmd,
    input  logic [IDX_W-1:0]            i_addr,
    input  logic [nps_pkg::ARR_W-1:0]   i_arrival_time,
    input  logic [nps_pkg::BUR_W-1:0]   i_burst_time,
    input  logic [nps_pkg::PRI_W-1:0]   i_priority_level,
    output nps_pkg::t_status            o_status,
    output logic [CNT_W-1:0]            o_count,
    output logic                        o_valid,
    output logic [nps_pkg::PID_W-1:0]   o_process_id,
    output logic [nps_pkg::TIME_W-1:0]  o_start_time,
    output logic [nps_pkg::TIME_W-1:0]  o_completion_time,
    output logic [nps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [nps_pkg::TIME_W-1:0]  o_waiting,
    output logic [nps_pkg::TOT_W-1:0]   o_total_turnaround,
    output logic [nps_pkg::TOT_W-1:0]   o_total_waiting,
    output logic                        o_last_result
);
    import nps_pkg::*;

    localparam int PROC_W = ARR_W + BUR_W + PRI_W;
    localparam int RES_W  = 2 * TIME_W;

    // Process store (arrival, burst, priority) and result store (start, finish).
    logic [PROC_W-1:0] r_proc_mem [MAX_PROCS];
    logic [RES_W-1:0]  r_res_mem  [MAX_PROCS];
    logic [PROC_W-1:0] r_proc_q;
    logic [RES_W-1:0]  r_res_q;

    logic [CNT_W-1:0]     r_count;
    logic [TIME_W-1:0]    r_clock;
    logic [MAX_PROCS-1:0] r_done;

    // Read pipeline markers.
    logic             r_scan_vld;
    logic             r_out_vld;
    logic             r_out_last;
    logic [IDX_W-1:0] r_ridx;

    // Selection trackers.
    logic             r_best_vld;
    logic [IDX_W-1:0] r_best_idx;
    logic [PRI_W-1:0] r_best_pri;
    logic [ARR_W-1:0] r_best_arr;
    logic [BUR_W-1:0] r_best_bur;
    logic             r_pend_vld;
    logic [ARR_W-1:0] r_pend_min;

    logic [TOT_W-1:0] r_tot_tat;
    logic [TOT_W-1:0] r_tot_wt;

    // Output registers.
    logic              r_valid;
    logic [PID_W-1:0]  r_pid;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_finish;
    logic [TIME_W-1:0] r_tat;
    logic [TIME_W-1:0] r_wt;
    logic [TOT_W-1:0]  r_tot_tat_o;
    logic [TOT_W-1:0]  r_tot_wt_o;
    logic              r_last;

    logic [ARR_W-1:0]  q_arr;
    logic [BUR_W-1:0]  q_bur;
    logic [PRI_W-1:0]  q_pri;
    logic [TIME_W-1:0] q_start;
    logic [TIME_W-1:0] q_finish;
    logic              has_room;
    logic              cand;
    logic              better;
    logic              pend_upd;
    logic [TIME_W-1:0] commit_end;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [TOT_W-1:0]  sum_tat;
    logic [TOT_W-1:0]  sum_wt;

    assign {q_arr, q_bur, q_pri} = r_proc_q;
    assign {q_start, q_finish}   = r_res_q;
    assign has_room = (r_count != CNT_W'(MAX_PROCS));

    // Scan comparison on the entry just read.
    assign cand = !r_done[r_ridx] && (TIME_W'(q_arr) <= r_clock);
    assign better = !r_best_vld || (q_pri > r_best_pri) ||
                    ((q_pri == r_best_pri) && (q_arr < r_best_arr));
    assign pend_upd = !r_done[r_ridx] && (!r_pend_vld || (q_arr < r_pend_min));
    assign commit_end = r_clock + TIME_W'(r_best_bur);

    // Result arithmetic on the entry just read.
    assign tat     = q_finish - TIME_W'(q_arr);
    assign wt      = tat - TIME_W'(q_bur);
    assign sum_tat = r_tot_tat + TOT_W'(tat);
    assign sum_wt  = r_tot_wt + TOT_W'(wt);

    assign o_status.found   = r_best_vld;
    assign o_status.pending = r_pend_vld;
    assign o_count          = r_count;

    // Process store: written on load, read during scans and output.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && has_room) begin
            r_proc_mem[r_count[IDX_W-1:0]] <= {i_arrival_time, i_burst_time, i_priority_level};
        end
        if (i_cmd.scan_rd || i_cmd.out_rd) begin
            r_proc_q <= r_proc_mem[i_addr];
        end
    end

    // Result store: written on commit, read during output.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_mem[r_best_idx] <= {r_clock, commit_end};
        end
        if (i_cmd.out_rd) begin
            r_res_q <= r_res_mem[i_addr];
        end
    end

    // Load count, clock and done flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clock <= '0;
            r_done  <= '0;
        end else if (i_cmd.finish) begin
            r_count <= '0;
            r_clock <= '0;
            r_done  <= '0;
        end else begin
            if (i_cmd.load && has_room) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_clock             <= commit_end;
                r_done[r_best_idx]  <= 1'b1;
            end else if (i_cmd.jump) begin
                r_clock <= TIME_W'(r_pend_min);
            end
        end
    end

    // Read pipeline markers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.scan_rd;
            r_out_vld  <= i_cmd.out_rd;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= i_addr;
    end

    // Best candidate and earliest pending arrival over one scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_best_vld <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (r_scan_vld) begin
            if (cand && better) begin
                r_best_vld <= 1'b1;
            end
            if (pend_upd) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_scan_vld && cand && better) begin
            r_best_idx <= r_ridx;
            r_best_pri <= q_pri;
            r_best_arr <= q_arr;
            r_best_bur <= q_bur;
        end
        if (r_scan_vld && pend_upd) begin
            r_pend_min <= q_arr;
        end
    end

    // Run totals.
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_tot_tat <= '0;
            r_tot_wt  <= '0;
        end else if (r_out_vld) begin
            r_tot_tat <= sum_tat;
            r_tot_wt  <= sum_wt;
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_out_vld;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (r_out_vld) begin
            r_pid       <= PID_W'(r_ridx) + PID_W'(1);
            r_start     <= q_start;
            r_finish    <= q_finish;
            r_tat       <= tat;
            r_wt        <= wt;
            r_tot_tat_o <= r_out_last ? sum_tat : '0;
            r_tot_wt_o  <= r_out_last ? sum_wt : '0;
            r_last      <= r_out_last;
        end
    end

    assign o_valid            = r_valid;
    assign o_process_id       = r_pid;
    assign o_start_time       = r_start;
    assign o_completion_time  = r_finish;
    assign o_turnaround       = r_tat;
    assign o_waiting          = r_wt;
    assign o_total_turnaround = r_tot_tat_o;
    assign o_total_waiting    = r_tot_wt_o;
    assign o_last_result      = r_last;

endmodule

[src/non_preemptive_priority_scheduler.sv]
// Loading takes one item per cycle while busy is low; the item that closes a set starts
// the run. Each scheduling decision is one pass over the n held processes through the
// process store's single read port; a run takes at most 2n + 1 passes (jumps to the next
// arrival included), then the n results follow, one per cycle. Results are strobed one
// cycle each and the receiver cannot stall. Synchronous active-low reset clears control
// state and flags.
module non_preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [nps_pkg::ARR_W-1:0]   i_arrival_time,
    input  logic [nps_pkg::BUR_W-1:0]   i_burst_time,
    input  logic [nps_pkg::PRI_W-1:0]   i_priority_level,
    input  logic                        i_last_process,
    output logic                        o_valid,
    output logic [nps_pkg::PID_W-1:0]   o_process_id,
    output logic [nps_pkg::TIME_W-1:0]  o_start_time,
    output logic [nps_pkg::TIME_W-1:0]  o_completion_time,
    output logic [nps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [nps_pkg::TIME_W-1:0]  o_waiting,
    output logic [nps_pkg::TOT_W-1:0]   o_total_turnaround,
    output logic [nps_pkg::TOT_W-1:0]   o_total_waiting,
    output logic                        o_last_result
);
    import nps_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] count;

    // Controller.
    nps_ctrl #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_last_process (i_last_process),
        .i_count        (count),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_addr         (addr),
        .busy           (busy)
    );

    // Datapath.
    nps_dpath #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_addr             (addr),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_priority_level   (i_priority_level),
        .o_status           (status),
        .o_count            (count),
        .o_valid            (o_valid),
        .o_process_id       (o_process_id),
        .o_start_time       (o_start_time),
        .o_completion_time  (o_completion_time),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting),
        .o_last_result      (o_last_result)
    );

endmodule

[test/non_preemptive_priority_scheduler_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the priority scheduler: a directed table, then random sets.
module non_preemptive_priority_scheduler_tb;
    import nps_pkg::*;

    localparam int MAX_PROCS    = 64;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_SHOWN    = 40;
    localparam int DIR_ROWS     = 14;

    // Shapes of the random process sets.
    typedef enum int {
        MIX_DENSE,
        MIX_SPREAD,
        MIX_FULL,
        MIX_ALL_AT_ZERO
    } t_mix;

    // One result item as the block reports it.
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_done;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
        logic [TOT_W-1:0]  sum_tat;
        logic [TOT_W-1:0]  sum_wt;
        logic              last;
    } t_proc_report;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [PRI_W-1:0] prio;
        logic             last;
        logic             typed;
        t_proc_report     want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [ARR_W-1:0]    i_arrival_time;
    logic [BUR_W-1:0]    i_burst_time;
    logic [PRI_W-1:0]    i_priority_level;
    logic                i_last_process;
    logic                o_valid;
    logic [PID_W-1:0]    o_process_id;
    logic [TIME_W-1:0]   o_start_time;
    logic [TIME_W-1:0]   o_completion_time;
    logic [TIME_W-1:0]   o_turnaround;
    logic [TIME_W-1:0]   o_waiting;
    logic [TOT_W-1:0]    o_total_turnaround;
    logic [TOT_W-1:0]    o_total_waiting;
    logic                o_last_result;

    // Process set held by the predictor, and the results it has worked out.
    logic [ARR_W-1:0]    held_arr [MAX_PROCS];
    logic [BUR_W-1:0]    held_bur [MAX_PROCS];
    logic [PRI_W-1:0]    held_pri [MAX_PROCS];
    bit                  held_done [MAX_PROCS];
    int                  held_count;
    t_proc_report        proc_reports_q [$];

    int n_errors;
    int n_items;
    int n_sets;
    int n_results;
    int n_dropped;

    // Directed table: single-process sets with results typed in, then mixed sets.
    t_dir_row dir_rows [DIR_ROWS] = '{
        // Zero arrival, zero burst, lowest priority.
        '{16'd0, 16'd0, 8'd0, 1'b1, 1'b1,
          '{7'd1, 23'd0, 23'd0, 23'd0, 23'd0, 29'd0, 29'd0, 1'b1}},
        // Largest arrival, burst and priority.
        '{16'd65535, 16'd65535, 8'd255, 1'b1, 1'b1,
          '{7'd1, 23'd65535, 23'd131070, 23'd65535, 23'd0, 29'd65535, 29'd0, 1'b1}},
        // Zero burst after a jump to a late arrival.
        '{16'd100, 16'd0, 8'd7, 1'b1, 1'b1,
          '{7'd1, 23'd100, 23'd100, 23'd0, 23'd0, 29'd0, 29'd0, 1'b1}},
        // Ties on priority, ties on arrival, an idle gap and a zero burst.
        '{16'd0,   16'd5, 8'd1,   1'b0, 1'b0, '0},
        '{16'd1,   16'd3, 8'd9,   1'b0, 1'b0, '0},
        '{16'd2,   16'd2, 8'd9,   1'b0, 1'b0, '0},
        '{16'd1,   16'd4, 8'd9,   1'b0, 1'b0, '0},
        '{16'd200, 16'd1, 8'd255, 1'b0, 1'b0, '0},
        '{16'd3,   16'd0, 8'd0,   1'b1, 1'b0, '0},
        // Arrival and burst at the top of their range, priority at both ends.
        '{16'd65535, 16'd65535, 8'd0,   1'b0, 1'b0, '0},
        '{16'd65535, 16'd65535, 8'd255, 1'b0, 1'b0, '0},
        '{16'd65535, 16'd65535, 8'd255, 1'b1, 1'b0, '0},
        // A high priority that has not yet arrived must not hold up the choice.
        '{16'd10, 16'd1,  8'd255, 1'b0, 1'b0, '0},
        '{16'd0,  16'd20, 8'd0,   1'b1, 1'b0, '0}
    };

    // Clock and device under test.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    non_preemptive_priority_scheduler #(.MAX_PROCS(MAX_PROCS)) dut (.*);

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_SHOWN)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [PID_W-1:0] pid,
                               input logic [TOT_W-1:0] got, input logic [TOT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("process %0d %s: got %0d, want %0d",
                                      pid, name, got, want));
    endtask

    // Best arrived, unfinished process at time now, or -1 when none has arrived.
    function automatic int pick_ready(input logic [TIME_W-1:0] now);
        int best;
        best = -1;
        for (int i = 0; i < held_count; i++) begin
            if (held_done[i] || TIME_W'(held_arr[i]) > now)
                continue;
            if (best < 0 || held_pri[i] > held_pri[best] ||
                (held_pri[i] == held_pri[best] && held_arr[i] < held_arr[best]))
                best = i;
        end
        return best;
    endfunction

    // Runs the held set without preemption and queues one result per process in id order.
    function automatic void run_schedule();
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] ran_from [MAX_PROCS];
        logic [TIME_W-1:0] ran_to [MAX_PROCS];
        logic [ARR_W-1:0]  next_arr;
        logic [TOT_W-1:0]  sum_tat;
        logic [TOT_W-1:0]  sum_wt;
        t_proc_report      rep;
        int                sel;
        now = '0;
        sum_tat = '0;
        sum_wt = '0;
        for (int i = 0; i < MAX_PROCS; i++)
            held_done[i] = 1'b0;
        for (int k = 0; k < held_count; k++) begin
            sel = pick_ready(now);
            if (sel < 0) begin
                // Nothing has arrived yet, so the clock jumps to the earliest pending arrival.
                next_arr = '1;
                for (int i = 0; i < held_count; i++)
                    if (!held_done[i] && held_arr[i] <= next_arr)
                        next_arr = held_arr[i];
                now = TIME_W'(next_arr);
                sel = pick_ready(now);
            end
            ran_from[sel] = now;
            now = now + TIME_W'(held_bur[sel]);
            ran_to[sel] = now;
            held_done[sel] = 1'b1;
        end
        for (int i = 0; i < held_count; i++) begin
            rep = '0;
            rep.pid = PID_W'(i + 1);
            rep.t_start = ran_from[i];
            rep.t_done = ran_to[i];
            rep.tat = ran_to[i] - TIME_W'(held_arr[i]);
            rep.wt = rep.tat - TIME_W'(held_bur[i]);
            sum_tat = sum_tat + TOT_W'(rep.tat);
            sum_wt = sum_wt + TOT_W'(rep.wt);
            if (i == held_count - 1) begin
                rep.sum_tat = sum_tat;
                rep.sum_wt = sum_wt;
                rep.last = 1'b1;
            end
            proc_reports_q.push_back(rep);
        end
        held_count = 0;
        for (int i = 0; i < MAX_PROCS; i++)
            held_done[i] = 1'b0;
    endfunction

    // Predictor step for one accepted item.
    function automatic void accept_process(input logic [ARR_W-1:0] arr,
                                           input logic [BUR_W-1:0] bur,
                                           input logic [PRI_W-1:0] pri, input logic last);
        if (held_count < MAX_PROCS) begin
            held_arr[held_count] = arr;
            held_bur[held_count] = bur;
            held_pri[held_count] = pri;
            held_count++;
        end else begin
            n_dropped++;
        end
        if (last) begin
            run_schedule();
            n_sets++;
        end
    endfunction

    // Presents one item and holds it until the block takes it.
    task automatic send_item(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                             input logic [PRI_W-1:0] pri, input logic last);
        start <= 1'b1;
        i_arrival_time <= arr;
        i_burst_time <= bur;
        i_priority_level <= pri;
        i_last_process <= last;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        accept_process(arr, bur, pri, last);
        n_items++;
    endtask

    // Random pause before an item, mostly short; the data ports carry junk meanwhile.
    task automatic idle_gap(input bit quiet);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            start <= 1'b0;
            i_arrival_time <= ARR_W'($urandom);
            i_burst_time <= BUR_W'($urandom);
            i_priority_level <= PRI_W'($urandom);
            i_last_process <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one set of random processes; the last item closes the set.
    task automatic send_random_set(input int size);
        t_mix             mix;
        bit               quiet;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
        logic [PRI_W-1:0] pri;
        mix = t_mix'($urandom_range(0, 3));
        quiet = ($urandom_range(0, 3) == 0);
        for (int idx = 1; idx <= size; idx++) begin
            case (mix)
                MIX_DENSE: begin
                    arr = ARR_W'($urandom_range(0, 30));
                    bur = BUR_W'($urandom_range(0, 20));
                    pri = PRI_W'($urandom_range(0, 3));
                end
                MIX_SPREAD: begin
                    arr = ARR_W'($urandom_range(0, 2000));
                    bur = BUR_W'($urandom_range(0, 300));
                    pri = PRI_W'($urandom_range(0, 15));
                end
                MIX_FULL: begin
                    arr = ARR_W'($urandom);
                    bur = BUR_W'($urandom);
                    pri = PRI_W'($urandom);
                end
                default: begin
                    arr = '0;
                    bur = BUR_W'($urandom_range(0, 9));
                    pri = PRI_W'($urandom_range(0, 1));
                end
            endcase
            // Now and then a process with fields over their whole range.
            if ($urandom_range(0, 9) == 0) begin
                arr = ARR_W'($urandom);
                bur = BUR_W'($urandom);
                pri = PRI_W'($urandom);
            end
            idle_gap(quiet);
            send_item(arr, bur, pri, idx == size);
        end
    endtask

    // Result checker: every strobed result is matched against the oldest outstanding one.
    always @(posedge i_clk) begin
        t_proc_report want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (proc_reports_q.size() == 0) begin
                report_mismatch($sformatf("result for process %0d with none outstanding",
                                          o_process_id));
            end else begin
                want = proc_reports_q.pop_front();
                check_field("process_id", want.pid, TOT_W'(o_process_id), TOT_W'(want.pid));
                check_field("start_time", want.pid, TOT_W'(o_start_time),
                            TOT_W'(want.t_start));
                check_field("completion_time", want.pid, TOT_W'(o_completion_time),
                            TOT_W'(want.t_done));
                check_field("turnaround", want.pid, TOT_W'(o_turnaround), TOT_W'(want.tat));
                check_field("waiting", want.pid, TOT_W'(o_waiting), TOT_W'(want.wt));
                check_field("total_turnaround", want.pid, o_total_turnaround, want.sum_tat);
                check_field("total_waiting", want.pid, o_total_waiting, want.sum_wt);
                check_field("last_result", want.pid, TOT_W'(o_last_result), TOT_W'(want.last));
                n_results++;
            end
        end
    end

    // Main sequence: reset, directed table, random sets, drain.
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_arrival_time = '0;
        i_burst_time = '0;
        i_priority_level = '0;
        i_last_process = 1'b0;
        held_count = 0;
        n_errors = 0;
        n_items = 0;
        n_sets = 0;
        n_results = 0;
        n_dropped = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            idle_gap(1'b0);
            send_item(dir_rows[r].arrival, dir_rows[r].burst, dir_rows[r].prio,
                      dir_rows[r].last);
            if (dir_rows[r].typed)
                proc_reports_q[proc_reports_q.size() - 1] = dir_rows[r].want;
        end

        // Small sets around a set that fills the store and one that overflows it.
        repeat (4) send_random_set($urandom_range(1, 8));
        send_random_set(MAX_PROCS);
        repeat (4) send_random_set($urandom_range(1, 8));
        send_random_set(MAX_PROCS + 2);
        repeat (3) send_random_set($urandom_range(1, 3));
        start <= 1'b0;

        while (proc_reports_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items in %0d process sets, %0d results checked.",
                 n_items, n_sets, n_results);
        $display("%0d items arrived at a full store; %0d mismatches seen.", n_dropped, n_errors);
        if (n_errors == 0)
            $display("non_preemptive_priority_scheduler_tb: done, clean");
        else
            $display("non_preemptive_priority_scheduler_tb: done, errors");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d results outstanding.", proc_reports_q.size());
        $display("non_preemptive_priority_scheduler_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
src/nps_pkg.sv
src/nps_ctrl.sv
src/nps_dpath.sv
src/non_preemptive_priority_scheduler.sv
test/non_preemptive_priority_scheduler_tb.sv
